[rtl/wlmpp_pkg.sv]
// shared constants, types and limits of the windowed local-maximum peak picker
`default_nettype none

package wlmpp_pkg;

  localparam int HALF_WINDOW = 24;
  localparam int WIN_DEPTH   = 2 * HALF_WINDOW + 1;
  localparam int MAX_FRAMES  = 65536;

  localparam int VAL_W   = 16;
  localparam int THR_W   = 15;
  localparam int IDX_W   = 16;
  localparam int FC_W    = 17;
  localparam int CNT_W   = 17;
  localparam int SUM_W   = 31;
  localparam int STEP_W  = $clog2(HALF_WINDOW + 2);
  localparam int IDX_CALC_W = FC_W + 1;

  localparam int OUT_FIELDS_W = THR_W + IDX_W + CNT_W + SUM_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam int FRAME_CAP_I = (MAX_FRAMES < 131071) ? MAX_FRAMES : 131071;

  localparam logic [FC_W-1:0]   FRAME_CAP = FC_W'(FRAME_CAP_I);
  localparam logic [CNT_W-1:0]  COUNT_CAP = '1;
  localparam logic [SUM_W-1:0]  SUM_CAP   = '1;
  localparam logic [THR_W-1:0]  THR_RESET = THR_W'(410);
  localparam logic [STEP_W-1:0] END_STEP  = STEP_W'(HALF_WINDOW + 1);
  localparam logic [IDX_CALC_W-1:0] IDX_OFFSET = IDX_CALC_W'(HALF_WINDOW + 1);
  localparam logic [IDX_CALC_W-1:0] IDX_MAX    = IDX_CALC_W'((1 << IDX_W) - 1);

  typedef logic signed [VAL_W-1:0] val_t;

  // delay line control from the sequencer
  typedef struct packed {
    logic shift;
    logic bit_in;
    logic clear;
  } win_ctl_t;

  // decision on the center slot of the delay line
  typedef struct packed {
    logic             hit;
    logic [THR_W-1:0] value;
  } judge_t;

endpackage

`default_nettype wire

[rtl/windowed_local_max_peak_picker.sv]
// top level of the windowed local-maximum peak picker
//
//   channel  dir  handshake             payload
//   in_      in   in_tvalid/in_tready   in_tdata: onset_value, in_tlast: last_of_list
//   out_     out  out_tvalid/out_tready out_tdata: value/index/count/sum, tuser, tlast
//   cfg_     in   cfg_wr_en             cfg_wr_data: peak_threshold
//
// one frame per cycle while the result register is free; the decision that a
// transaction leaves pending is taken by the single result register once it is free
// a last frame closes the input for the drain: the 25 pending frames are decided
// one per cycle while the result register is free, then the end marker is loaded
// rst_n clears the window valid bits, counters and threshold (to 410)
// a stalled result blocks a further decision but not an input transaction
// whose decision slot is free
`default_nettype none

module windowed_local_max_peak_picker
  import wlmpp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [VAL_W-1:0]      in_tdata,     // [15:0] onset_value
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,    // peak_value, peak_index, peak_count, peak_sum, pad
  output logic [0:0]                 out_tuser,    // [0] is_peak
  output logic                       out_tlast,
  input  wire logic                  cfg_wr_en,
  input  wire logic [THR_W-1:0]      cfg_wr_data
);

  logic [THR_W-1:0]     thr_r, thr_nxt;
  win_ctl_t             win_ctl;
  val_t                 win_val [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] win_valid;
  judge_t               jdg;

  assign thr_nxt = cfg_wr_en ? cfg_wr_data : thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  wlmpp_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (win_ctl),
    .data_in   (val_t'(in_tdata)),
    .win_val   (win_val),
    .win_valid (win_valid)
  );

  wlmpp_judge u_judge (
    .win_val   (win_val),
    .win_valid (win_valid),
    .threshold (thr_r),
    .result    (jdg)
  );

  wlmpp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .jdg        (jdg),
    .win_ctl    (win_ctl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[rtl/wlmpp_window.sv]
// delay line of onset values with one valid bit per slot, slot 0 newest
`default_nettype none

module wlmpp_window
  import wlmpp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire win_ctl_t             ctl,
  input  wire val_t                 data_in,
  output val_t                      win_val [WIN_DEPTH],
  output logic [WIN_DEPTH-1:0]      win_valid
);

  val_t                 store_r [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] valid_r;
  logic [WIN_DEPTH-1:0] valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = '0;
    end else if (ctl.shift) begin
      valid_nxt = {valid_r[WIN_DEPTH-2:0], ctl.bit_in};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      store_r[0] <= data_in;
      for (int k = 1; k < WIN_DEPTH; k++) begin
        store_r[k] <= store_r[k-1];
      end
    end
  end

  assign win_val   = store_r;
  assign win_valid = valid_r;

endmodule

`default_nettype wire

[rtl/wlmpp_judge.sv]
// parallel compare of the center slot against every valid slot of the window
`default_nettype none

module wlmpp_judge
  import wlmpp_pkg::*;
(
  input  wire val_t                 win_val [WIN_DEPTH],
  input  wire logic [WIN_DEPTH-1:0] win_valid,
  input  wire logic [THR_W-1:0]     threshold,
  output judge_t                    result
);

  val_t ctr;
  val_t thr_s;
  logic hit;

  always_comb begin
    ctr   = win_val[HALF_WINDOW];
    thr_s = val_t'({1'b0, threshold});
    hit   = win_valid[HALF_WINDOW] && (ctr > thr_s);
    // slots outside the list carry a cleared valid bit and are skipped
    for (int j = 0; j < WIN_DEPTH; j++) begin
      if (win_valid[j] && (win_val[j] > ctr)) begin
        hit = 1'b0;
      end
    end
    result.hit   = hit;
    result.value = ctr[THR_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/wlmpp_ctrl.sv]
// sequencer, frame counter, peak totals and result register
`default_nettype none

module wlmpp_ctrl
  import wlmpp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tlast,
  output logic                       in_tready,
  input  wire judge_t                jdg,
  output win_ctl_t                   win_ctl,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [0:0]                 out_tuser,
  output logic                       out_tlast
);

  logic              dec_pend_r, dec_pend_nxt;
  logic              drain_r, drain_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [THR_W-1:0]  out_val_r, out_val_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_peak_r, out_peak_nxt;
  logic              out_end_r, out_end_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [SUM_W-1:0]  out_sum_r, out_sum_nxt;

  logic                  out_free;
  logic                  adv;
  logic                  acc;
  logic                  drain_done;
  logic                  emit;
  logic [STEP_W-1:0]     step_sel;
  logic [IDX_CALC_W-1:0] idx_full;
  logic [IDX_W-1:0]      idx_sat;
  logic [SUM_W:0]        sum_add;

  assign out_free   = !out_valid_r || out_tready;
  assign adv        = (dec_pend_r || drain_r) && out_free;
  assign in_tready  = !drain_r && (!dec_pend_r || out_free);
  assign acc        = in_tvalid && in_tready;
  assign drain_done = drain_r && (step_r == END_STEP);
  assign emit       = adv && !drain_done && jdg.hit;

  // each drain step but the last pushes a bubble, so the center slot walks toward the newest frame
  assign win_ctl.shift  = acc || (adv && drain_r && !drain_done);
  assign win_ctl.bit_in = acc;
  assign win_ctl.clear  = adv && drain_done;

  always_comb begin
    step_sel = drain_r ? step_r : '0;
    idx_full = {1'b0, fc_r} + {{(IDX_CALC_W-STEP_W){1'b0}}, step_sel} - IDX_OFFSET;
    idx_sat  = (idx_full > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : idx_full[IDX_W-1:0];
    sum_add  = {1'b0, sum_r} + {{(SUM_W+1-THR_W){1'b0}}, jdg.value};
  end

  always_comb begin
    dec_pend_nxt = dec_pend_r;
    drain_nxt    = drain_r;
    step_nxt     = step_r;
    fc_nxt       = fc_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;

    if (adv) begin
      dec_pend_nxt = 1'b0;
      if (drain_r) begin
        step_nxt = step_r + STEP_W'(1);
      end
    end

    if (emit) begin
      if (cnt_r != COUNT_CAP) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      sum_nxt = (sum_add > {1'b0, SUM_CAP}) ? SUM_CAP : sum_add[SUM_W-1:0];
    end

    if (win_ctl.clear) begin
      drain_nxt = 1'b0;
      step_nxt  = '0;
      fc_nxt    = '0;
      cnt_nxt   = '0;
      sum_nxt   = '0;
    end

    if (acc) begin
      if (fc_r < FRAME_CAP) begin
        fc_nxt = fc_r + FC_W'(1);
      end
      if (in_tlast) begin
        drain_nxt = 1'b1;
        step_nxt  = '0;
      end else begin
        dec_pend_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_idx_nxt   = out_idx_r;
    out_peak_nxt  = out_peak_r;
    out_end_nxt   = out_end_r;
    out_cnt_nxt   = out_cnt_r;
    out_sum_nxt   = out_sum_r;
    if (out_free) begin
      out_valid_nxt = emit || (adv && drain_done);
      if (drain_done) begin
        out_val_nxt  = '0;
        out_idx_nxt  = '0;
        out_peak_nxt = 1'b0;
        out_end_nxt  = 1'b1;
        out_cnt_nxt  = cnt_r;
        out_sum_nxt  = sum_r;
      end else begin
        out_val_nxt  = jdg.value;
        out_idx_nxt  = idx_sat;
        out_peak_nxt = 1'b1;
        out_end_nxt  = 1'b0;
        out_cnt_nxt  = '0;
        out_sum_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_pend_r  <= 1'b0;
      drain_r     <= 1'b0;
      step_r      <= '0;
      fc_r        <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dec_pend_r  <= dec_pend_nxt;
      drain_r     <= drain_nxt;
      step_r      <= step_nxt;
      fc_r        <= fc_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r  <= out_val_nxt;
    out_idx_r  <= out_idx_nxt;
    out_peak_r <= out_peak_nxt;
    out_end_r  <= out_end_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_sum_r  <= out_sum_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_sum_r, out_cnt_r, out_idx_r, out_val_r};
  assign out_tuser  = out_peak_r;
  assign out_tlast  = out_end_r;

endmodule

`default_nettype wire

[rtl/wlmpp_check.sv]
// port-level checks of the peak picker, bound to the top level
`default_nettype none

module wlmpp_check
  import wlmpp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  in_tlast,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [0:0]            out_tuser,
  input wire logic                  out_tlast
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // the last frame starts the drain, so input closes right after it
  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input open after last frame");

  // an end marker reports no peak and has a cleared value and index
  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser[0] && (out_tdata[THR_W+IDX_W-1:0] == '0))
    else $error("malformed end marker");

  // a peak report is never an end marker and carries a nonzero value
  a_peak_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tlast && (out_tdata[THR_W-1:0] != '0))
    else $error("malformed peak report");

endmodule

bind windowed_local_max_peak_picker wlmpp_check u_check (.*);

`default_nettype wire
